// File: sv/mms_pkg.sv
// mms_pkg: shared constants, types and the controller state for the
// modulation matrix sum block. No dependencies.
package mms_pkg;

   // sizes
   localparam int SLOTS         = 8;   // slots taking part in a sum, 1 .. 8
   localparam int SOURCES       = 16;  // entries of the source store, 1 .. 16
   localparam int NUM_SLOT_REGS = 8;

   localparam int SLOT_W      = 26;
   localparam int SLOT_IDX_W  = $clog2(NUM_SLOT_REGS);
   localparam int CSR_IDX_W   = 4;
   localparam int SRC_IDX_W   = (SOURCES > 1) ? $clog2(SOURCES) : 1;
   localparam int IDX_W       = 4;   // source / dest fields
   localparam int VAL_W       = 16;  // Q1.15
   localparam int BASE_W      = 24;  // Q8.15
   localparam int OPA_W       = VAL_W + 2;
   localparam int PROD_W      = OPA_W + VAL_W;
   localparam int ACC_W       = 42;
   localparam int RND_SHIFT   = 16;

   localparam logic [SLOT_W-1:0] SLOT_RESET = SLOT_W'(26'h100_0000);

   // slot word packing
   localparam int SL_SRC_LO   = 0;
   localparam int SL_DST_LO   = 4;
   localparam int SL_DEPTH_LO = 8;
   localparam int SL_BIPOLAR  = 24;
   localparam int SL_ACTIVE   = 25;

   // request kinds
   localparam logic KIND_STORE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } mms_state_type;

   typedef struct packed {
      logic store;    // write source store from the request
      logic start;    // latch dest/base, clear slot counter
      logic mac;      // issue one slot product
      logic finish;   // round, saturate, load response register
   } mms_cmd_type;

   typedef struct packed {
      logic last_slot;
      logic out_full;
   } mms_status_type;

endpackage

// File: sv/mms_ctrl.sv
// mms_ctrl: sequencer for the modulation matrix sum.
// Depends on mms_pkg.
module mms_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_kind,
   output logic                    req_ready,
   input  mms_pkg::mms_status_type status,
   output mms_pkg::mms_cmd_type    cmd
);
   import mms_pkg::*;

   mms_state_type state_ff, state_in;
   logic          accept;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_kind == KIND_QUERY) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (status.last_slot) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.out_full) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.store = req_valid && req_kind == KIND_STORE;
            cmd.start = req_valid && req_kind == KIND_QUERY;
         end
         ST_RUN: begin
            cmd.mac = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            cmd.finish = !status.out_full;
         end
         default: begin
         end
      endcase
   end

   a_store_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> accept && req_kind == KIND_STORE)
      else $error("store issued without an accepted store request");

   a_run_to_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && status.last_slot) |=> state_ff == ST_DRAIN)
      else $error("slot sweep did not end in drain");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !status.out_full)
      else $error("response register overwritten while held");

   a_start_from_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> state_ff == ST_RUN)
      else $error("query start did not enter slot sweep");

endmodule

// File: sv/mms_datapath.sv
// mms_datapath: slot registers, source store, slot multiplier, accumulator
// and the rounding/saturating response register. Depends on mms_pkg.
module mms_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [mms_pkg::IDX_W-1:0]         req_source_index,
   input  logic signed [mms_pkg::VAL_W-1:0]  req_source_value,
   input  logic [mms_pkg::IDX_W-1:0]         req_dest_index,
   input  logic signed [mms_pkg::BASE_W-1:0] req_base_value,
   input  logic                              csr_we,
   input  logic [mms_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mms_pkg::SLOT_W-1:0]        csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [mms_pkg::BASE_W-1:0] rsp_modulated_value,
   output logic                              rsp_saturated,
   input  mms_pkg::mms_cmd_type              cmd,
   output mms_pkg::mms_status_type           status
);
   import mms_pkg::*;

   localparam logic signed [ACC_W-RND_SHIFT-1:0] OUT_MAX =
      (ACC_W-RND_SHIFT)'(8388607);
   localparam logic signed [ACC_W-RND_SHIFT-1:0] OUT_MIN =
      -(ACC_W-RND_SHIFT)'(8388608);

   logic [SLOT_W-1:0]        slot_ff [NUM_SLOT_REGS];
   logic signed [VAL_W-1:0]  src_ff  [SOURCES];
   logic [SLOT_IDX_W-1:0]    cnt_ff;
   logic [IDX_W-1:0]         dest_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_en_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     rsp_valid_ff;
   logic signed [BASE_W-1:0] rsp_value_ff;
   logic                     rsp_sat_ff;

   logic [SLOT_W-1:0]                 word;
   logic [IDX_W-1:0]                  w_src;
   logic signed [VAL_W-1:0]           w_depth;
   logic                              match;
   logic signed [VAL_W-1:0]           v;
   logic signed [OPA_W-1:0]           opa;
   logic signed [ACC_W-1:0]           rnd_sum;
   logic signed [ACC_W-RND_SHIFT-1:0] rnd;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOT_REGS; i++) slot_ff[i] <= SLOT_RESET;
      end else if (csr_we && csr_index < CSR_IDX_W'(NUM_SLOT_REGS)) begin
         slot_ff[csr_index[SLOT_IDX_W-1:0]] <= csr_wdata;
      end
   end

   // source store; out-of-range stores dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SOURCES; i++) src_ff[i] <= '0;
      end else if (cmd.store && {1'b0, req_source_index} < (IDX_W+1)'(SOURCES)) begin
         src_ff[req_source_index[SRC_IDX_W-1:0]] <= req_source_value;
      end
   end

   // slot term for the current counter position
   always_comb begin
      word    = slot_ff[cnt_ff];
      w_src   = word[SL_SRC_LO +: IDX_W];
      w_depth = $signed(word[SL_DEPTH_LO +: VAL_W]);
      match   = word[SL_ACTIVE] && word[SL_DST_LO +: IDX_W] == dest_ff;
      v       = '0;
      if ({1'b0, w_src} < (IDX_W+1)'(SOURCES)) v = src_ff[w_src[SRC_IDX_W-1:0]];
      // bipolar: 2v; unipolar: (v + 1) / 2 as unsigned Q0.16
      if (word[SL_BIPOLAR]) opa = $signed({v[VAL_W-1], v, 1'b0});
      else                  opa = $signed({2'b00, ~v[VAL_W-1], v[VAL_W-2:0]});
      // signed product, kept out of a mixed-sign select
      prod_in = '0;
      if (match) prod_in = opa * w_depth;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         prod_en_ff <= 1'b0;
      end else begin
         prod_en_ff <= cmd.mac;
         if (cmd.start)    cnt_ff <= '0;
         else if (cmd.mac) cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.start) begin
         dest_ff <= req_dest_index;
         acc_ff  <= ACC_W'($signed({req_base_value, 16'h0000}));
      end else if (prod_en_ff) begin
         acc_ff  <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // round half up to Q8.15, then clip
   always_comb begin
      rnd_sum = acc_ff + ACC_W'(32768);
      rnd     = rnd_sum[ACC_W-1:RND_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (rnd > OUT_MAX) begin
            rsp_value_ff <= OUT_MAX[BASE_W-1:0];
            rsp_sat_ff   <= 1'b1;
         end else if (rnd < OUT_MIN) begin
            rsp_value_ff <= OUT_MIN[BASE_W-1:0];
            rsp_sat_ff   <= 1'b1;
         end else begin
            rsp_value_ff <= rnd[BASE_W-1:0];
            rsp_sat_ff   <= 1'b0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_modulated_value = rsp_value_ff;
   assign rsp_saturated       = rsp_sat_ff;

   assign status.last_slot = cnt_ff == SLOT_IDX_W'(SLOTS - 1);
   assign status.out_full  = rsp_valid_ff && !rsp_ready;

endmodule

// File: sv/modulation_matrix_sum.sv
// modulation_matrix_sum: top level of the modulation matrix.
// Depends on mms_pkg, mms_ctrl and mms_datapath.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_ready   kind, source index/value, dest, base
//  rsp      out        rsp_valid/rsp_ready   modulated value, saturated flag
//  csr      in         csr_we                csr_index, csr_wdata (slot word)
//
// A store request gives no response. A query request occupies the block
// from its accepting cycle on: that cycle latches dest and base, then one
// slot per cycle goes through the single slot multiplier, a drain step
// moves the last product into the accumulator, and a final step rounds
// and loads the response register. The response is valid in the next
// cycle, when the next request can be taken.
// Synchronous reset clears slots to inactive bipolar and the store to zero.
// A held response stalls only the next query at its final step; store
// requests keep being taken meanwhile.
module modulation_matrix_sum (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [mms_pkg::IDX_W-1:0]         req_source_index,
   input  logic signed [mms_pkg::VAL_W-1:0]  req_source_value,
   input  logic [mms_pkg::IDX_W-1:0]         req_dest_index,
   input  logic signed [mms_pkg::BASE_W-1:0] req_base_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [mms_pkg::BASE_W-1:0] rsp_modulated_value,
   output logic                              rsp_saturated,
   input  logic                              csr_we,
   input  logic [mms_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mms_pkg::SLOT_W-1:0]        csr_wdata
);
   import mms_pkg::*;

   mms_cmd_type    cmd;
   mms_status_type status;

   // sequencer: accepts requests, steps the slot sweep
   mms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: slots, store, multiply-accumulate, response register
   mms_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_source_index    (req_source_index),
      .req_source_value    (req_source_value),
      .req_dest_index      (req_dest_index),
      .req_base_value      (req_base_value),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_modulated_value (rsp_modulated_value),
      .rsp_saturated       (rsp_saturated),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for modulation_matrix_sum: a directed table, then
// random phases each under its own slot setting. Depends on mms_pkg and the block.
module tb;
   import mms_pkg::*;

   // a store may still be landing when the last response leaves
   localparam int SETTLE_CYCLES  = 2 * (SLOTS + 3);
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_REQUESTS = 225;

   localparam logic signed [BASE_W-1:0] BASE_MAX = 24'sh7F_FFFF;
   localparam logic signed [BASE_W-1:0] BASE_MIN = 24'sh80_0000;
   localparam logic signed [VAL_W-1:0]  VAL_MAX  = 16'sh7FFF;
   localparam logic signed [VAL_W-1:0]  VAL_MIN  = 16'sh8000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_0   = 0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_1   = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_2   = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_7   = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(NUM_SLOT_REGS);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = '1;

   typedef struct packed {
      logic signed [BASE_W-1:0] value;
      logic                     sat;
   } mod_result_type;

   typedef enum logic { ROW_REQUEST, ROW_CSR } row_op_type;

   typedef struct {
      row_op_type               op;
      logic                     kind;
      logic [IDX_W-1:0]         src;
      logic signed [VAL_W-1:0]  value;
      logic [IDX_W-1:0]         dest;
      logic signed [BASE_W-1:0] base;
      bit                       typed;   // expected result given in the row
      mod_result_type           want;
      logic [CSR_IDX_W-1:0]     reg_idx;
      logic [SLOT_W-1:0]        reg_word;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_kind = KIND_STORE;
   logic [IDX_W-1:0] req_source_index = '0;
   logic signed [VAL_W-1:0] req_source_value = '0;
   logic [IDX_W-1:0] req_dest_index = '0;
   logic signed [BASE_W-1:0] req_base_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [BASE_W-1:0] rsp_modulated_value;
   logic rsp_saturated;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SLOT_W-1:0] csr_wdata = '0;

   // local copy of the block state
   logic [SLOT_W-1:0]       slot_model [NUM_SLOT_REGS];
   logic signed [VAL_W-1:0] source_model [SOURCES];

   mod_result_type expected_results[$];
   stim_row_type   directed_rows[$];
   int             error_count = 0;
   bit             req_gaps_on = 1'b1;
   bit             rsp_gaps_on = 1'b1;

   modulation_matrix_sum i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_source_index    (req_source_index),
      .req_source_value    (req_source_value),
      .req_dest_index      (req_dest_index),
      .req_base_value      (req_base_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_modulated_value (rsp_modulated_value),
      .rsp_saturated       (rsp_saturated),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

   // mostly back to back, some short gaps, the odd long one
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [SLOT_W-1:0] pack_slot(input bit active, input bit bipolar,
         input logic signed [VAL_W-1:0] depth, input logic [IDX_W-1:0] dst,
         input logic [IDX_W-1:0] src);
      logic [SLOT_W-1:0] w;
      w = '0;
      w[SL_ACTIVE] = active;
      w[SL_BIPOLAR] = bipolar;
      w[SL_DEPTH_LO +: VAL_W] = depth;
      w[SL_DST_LO +: IDX_W] = dst;
      w[SL_SRC_LO +: IDX_W] = src;
      return w;
   endfunction

   // base plus the sum of every active slot aimed at dest, exact in Q.31,
   // rounded half up to Q8.15 and clipped
   function automatic mod_result_type predict_query(input logic [IDX_W-1:0] dest,
         input logic signed [BASE_W-1:0] base);
      mod_result_type res;
      logic [SLOT_W-1:0] w;
      longint acc;
      longint v;
      longint depth;
      longint rnd;
      acc = longint'(base) * 65536;
      for (int i = 0; i < SLOTS; i++) begin
         w = slot_model[i];
         if (w[SL_ACTIVE] && w[SL_DST_LO +: IDX_W] == dest) begin
            // a source index past the store reads as zero
            v = (w[SL_SRC_LO +: IDX_W] < SOURCES) ?
                longint'(source_model[w[SL_SRC_LO +: IDX_W]]) : 0;
            depth = longint'($signed(w[SL_DEPTH_LO +: VAL_W]));
            if (w[SL_BIPOLAR]) acc += 2 * v * depth;
            else acc += (v + 32768) * depth;   // (v+1)/2 as unsigned Q0.16
         end
      end
      rnd = (acc + 32768) >>> 16;
      res.sat = 1'b0;
      if (rnd > 8388607) begin
         rnd = 8388607;
         res.sat = 1'b1;
      end else if (rnd < -8388608) begin
         rnd = -8388608;
         res.sat = 1'b1;
      end
      res.value = BASE_W'(rnd);
      return res;
   endfunction

   function automatic stim_row_type store_row(input logic [IDX_W-1:0] src,
         input logic signed [VAL_W-1:0] value);
      stim_row_type r;
      r = '{op: ROW_REQUEST, kind: KIND_STORE, src: src, value: value, default: '0};
      return r;
   endfunction

   function automatic stim_row_type query_row(input logic [IDX_W-1:0] dest,
         input logic signed [BASE_W-1:0] base);
      stim_row_type r;
      r = '{op: ROW_REQUEST, kind: KIND_QUERY, dest: dest, base: base, default: '0};
      return r;
   endfunction

   function automatic stim_row_type known_row(input logic [IDX_W-1:0] dest,
         input logic signed [BASE_W-1:0] base, input logic signed [BASE_W-1:0] value,
         input logic sat);
      stim_row_type r;
      r = query_row(dest, base);
      r.typed = 1'b1;
      r.want = '{value, sat};
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
         input logic [SLOT_W-1:0] word);
      stim_row_type r;
      r = '{op: ROW_CSR, reg_idx: idx, reg_word: word, default: '0};
      return r;
   endfunction

   // one request through the valid/ready handshake, then update the model
   task automatic issue_request(input logic kind, input logic [IDX_W-1:0] src,
         input logic signed [VAL_W-1:0] value, input logic [IDX_W-1:0] dest,
         input logic signed [BASE_W-1:0] base, input bit typed,
         input mod_result_type want);
      int gap;
      mod_result_type res;
      gap = req_gaps_on ? gap_len() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_source_index <= src;
      req_source_value <= value;
      req_dest_index <= dest;
      req_base_value <= base;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (kind == KIND_STORE) begin
         if (src < SOURCES) source_model[src] = value;
      end else begin
         res = typed ? want : predict_query(dest, base);
         expected_results.push_back(res);
      end
   endtask

   // block idle: nothing outstanding, and time for a late store to land
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [SLOT_W-1:0] word);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= word;
      @(posedge clock);
      if (idx < NUM_SLOT_REGS) slot_model[idx] = word;
   endtask

   // response side: check at the edge, then choose ready for the next cycle
   initial begin
      mod_result_type want;
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: response with none outstanding: expected none, got %0d sat %0b",
                        $time, rsp_modulated_value, rsp_saturated);
            end else begin
               want = expected_results.pop_front();
               if (rsp_modulated_value !== want.value) begin
                  error_count++;
                  $display("%0t: modulated_value expected %0d, got %0d",
                           $time, $signed(want.value), rsp_modulated_value);
               end
               if (rsp_saturated !== want.sat) begin
                  error_count++;
                  $display("%0t: saturated expected %0b, got %0b",
                           $time, want.sat, rsp_saturated);
               end
            end
         end
         if (stall != 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (rsp_gaps_on && $urandom_range(0, 3) == 0) begin
            stall = gap_len();
            rsp_ready <= (stall == 0);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      bit in_csr;
      logic kind;
      logic [IDX_W-1:0] src;
      logic [IDX_W-1:0] dest;
      logic signed [VAL_W-1:0] value;
      logic signed [BASE_W-1:0] base;
      logic [SLOT_W-1:0] word;
      int pick;

      for (int i = 0; i < NUM_SLOT_REGS; i++) slot_model[i] = SLOT_RESET;
      for (int i = 0; i < SOURCES; i++) source_model[i] = '0;

      // after reset every slot is inactive: a query returns its base
      directed_rows.push_back(known_row(4'd0, 24'sd0, 24'sd0, 1'b0));
      directed_rows.push_back(known_row(4'd15, BASE_MAX, BASE_MAX, 1'b0));
      directed_rows.push_back(known_row(4'd5, BASE_MIN, BASE_MIN, 1'b0));
      directed_rows.push_back(store_row(4'd0, VAL_MAX));
      directed_rows.push_back(store_row(4'd15, VAL_MIN));
      directed_rows.push_back(store_row(4'd3, 16'sd1));
      directed_rows.push_back(known_row(4'd0, 24'sd1, 24'sd1, 1'b0));
      // full-scale bipolar, full-scale negative unipolar, rounding tie, -1 * -1
      directed_rows.push_back(csr_row(CSR_SLOT_0,
                                      pack_slot(1'b1, 1'b1, VAL_MAX, 4'd0, 4'd0)));
      directed_rows.push_back(csr_row(CSR_SLOT_1,
                                      pack_slot(1'b1, 1'b0, VAL_MIN, 4'd1, 4'd0)));
      directed_rows.push_back(csr_row(CSR_SLOT_2,
                                      pack_slot(1'b1, 1'b1, 16'sd16384, 4'd2, 4'd3)));
      directed_rows.push_back(csr_row(CSR_SLOT_7,
                                      pack_slot(1'b1, 1'b1, VAL_MIN, 4'd15, 4'd15)));
      // writes past the last slot register must not alias onto a slot
      directed_rows.push_back(csr_row(CSR_SPARE_LO, '1));
      directed_rows.push_back(csr_row(CSR_SPARE_HI, '1));
      directed_rows.push_back(known_row(4'd0, BASE_MAX, BASE_MAX, 1'b1));
      directed_rows.push_back(known_row(4'd1, BASE_MIN, BASE_MIN, 1'b1));
      directed_rows.push_back(query_row(4'd15, 24'sd8355839));   // lands on the top
      directed_rows.push_back(query_row(4'd15, 24'sd8355840));   // one past it
      directed_rows.push_back(query_row(4'd2, 24'sd0));          // tie rounds up
      directed_rows.push_back(store_row(4'd3, -16'sd1));
      directed_rows.push_back(query_row(4'd2, 24'sd0));          // negative tie
      directed_rows.push_back(known_row(4'd4, -24'sd77, -24'sd77, 1'b0));
      directed_rows.push_back(store_row(4'd0, 16'sd0));
      directed_rows.push_back(query_row(4'd0, 24'sd5));
      directed_rows.push_back(query_row(4'd1, 24'sd0));          // unipolar offset alone
      directed_rows.push_back(store_row(4'd0, VAL_MIN));
      directed_rows.push_back(query_row(4'd0, BASE_MIN));

      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      in_csr = 1'b0;
      foreach (directed_rows[n]) begin
         if (directed_rows[n].op == ROW_CSR) begin
            if (!in_csr) wait_idle();
            in_csr = 1'b1;
            write_csr(directed_rows[n].reg_idx, directed_rows[n].reg_word);
         end else begin
            if (in_csr) csr_we <= 1'b0;
            in_csr = 1'b0;
            issue_request(directed_rows[n].kind, directed_rows[n].src,
                          directed_rows[n].value, directed_rows[n].dest,
                          directed_rows[n].base, directed_rows[n].typed,
                          directed_rows[n].want);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         // some phases run with no idling on one side or both
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < NUM_SLOT_REGS; i++) begin
            case (phase)
               0: word = pack_slot(1'b1, 1'b1, VAL_MAX, 4'd0, IDX_W'(i));
               1: word = pack_slot(1'b1, 1'(i % 2), VAL_MIN, IDX_W'(i % 2), IDX_W'(i));
               2: word = '0;
               default: begin
                  word = SLOT_W'($urandom());
                  word[SL_ACTIVE] = ($urandom_range(0, 3) != 0);
                  // crowd slots onto a few destinations
                  if ($urandom_range(0, 1) == 1) word[SL_DST_LO + 2 +: 2] = '0;
               end
            endcase
            write_csr(CSR_SLOT_0 + CSR_IDX_W'(i), word);
         end
         write_csr(CSR_IDX_W'($urandom_range(NUM_SLOT_REGS, 2 ** CSR_IDX_W - 1)),
                   SLOT_W'($urandom()));
         csr_we <= 1'b0;

         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            kind = ($urandom_range(0, 1) == 1) ? KIND_QUERY : KIND_STORE;
            src = IDX_W'($urandom());
            pick = $urandom_range(0, 99);
            if (pick < 3) value = VAL_MAX;
            else if (pick < 6) value = VAL_MIN;
            else if (pick < 8) value = '0;
            else if (pick < 10) value = '1;
            else value = VAL_W'($urandom());
            if ($urandom_range(0, 9) < 7)
               dest = slot_model[$urandom_range(0, SLOTS - 1)][SL_DST_LO +: IDX_W];
            else
               dest = IDX_W'($urandom());
            pick = $urandom_range(0, 99);
            if (pick < 4) base = BASE_MAX;
            else if (pick < 8) base = BASE_MIN;
            else if (pick < 35) base = BASE_W'(int'($urandom_range(0, 131071)) - 65536);
            else base = BASE_W'($urandom());
            issue_request(kind, src, value, dest, base, 1'b0, '0);
         end
      end

      wait_idle();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
